@@ hw/rtl/atrsp_pkg.sv @@
package atrsp_pkg;

   localparam int LineBuf    = 96;
   localparam int MaxSockets = 4;
   localparam int MaxChunk   = 1100;
   localparam int AddrW      = $clog2(LineBuf);
   localparam int LenW       = $clog2(LineBuf + 1);
   localparam logic [11:0] NumCap = 12'd4095;

   typedef enum logic [3:0] {
      EV_OK = 4'd0, EV_ERROR = 4'd1, EV_SEND_OK = 4'd2, EV_SEND_FAIL = 4'd3,
      EV_PROMPT = 4'd4, EV_READY = 4'd5, EV_DATA = 4'd6, EV_CLOSED = 4'd7,
      EV_WIFI_UP = 4'd8, EV_WIFI_DOWN = 4'd9, EV_PING = 4'd10,
      EV_RESOLVE = 4'd11, EV_SCAN = 4'd12, EV_DESYNC = 4'd13
   } event_type;

   typedef enum logic [0:0] { CMD_BYTE = 1'b0, CMD_NEWCONN = 1'b1 } cmd_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]         event_res;
      logic [1:0]         socket_id;
      logic [7:0]         payload_byte;
      logic               chunk_last;
      logic signed [31:0] event_value;
   } rsp_type;

   // text patterns, first character in the top byte
   localparam logic [8*10-1:0] TxtOk       = {"OK",        64'h0};
   localparam logic [8*10-1:0] TxtError    = {"ERROR:",    32'h0};
   localparam logic [8*10-1:0] TxtSendOk   = {"SEND OK",   24'h0};
   localparam logic [8*10-1:0] TxtSendFail = {"SEND FAIL", 8'h0};
   localparam logic [8*10-1:0] TxtPrompt   = {">",         72'h0};
   localparam logic [8*10-1:0] TxtReady    = {"+READY",    32'h0};
   localparam logic [8*10-1:0] TxtSclosed  = {"+SCLOSED:", 8'h0};
   localparam logic [8*10-1:0] TxtWjoin    = {"+WJOIN:",   24'h0};
   localparam logic [8*10-1:0] TxtWconn    = {"+WCONN:",   24'h0};
   localparam logic [8*10-1:0] TxtWdisc    = {"+WDISCONN", 8'h0};
   localparam logic [8*10-1:0] TxtPing     = {"+PING:",    32'h0};
   localparam logic [8*10-1:0] TxtPingstat = "+PINGSTAT:";
   localparam logic [8*10-1:0] TxtResolve  = {"+RESOLVE:", 8'h0};
   localparam logic [8*10-1:0] TxtWscan    = {"+WSCAN:",   24'h0};
   localparam logic [8*7-1:0]  TxtSrecv    = "+SRECV:";

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0b) ||
             (c == 8'h0c);
   endfunction

endpackage

@@ hw/rtl/at_response_stream_parser_unit.sv @@
// AT response stream parser.
// req_ channel: one request per received byte (cmd = 0) or a new-connection
// marker (cmd = 1, clears payload-seen and desync state, no response).
// rsp_ channel: at most one event per request. In data mode every byte gives
// a data event tagged with its socket and a last flag, by way of ST_PEND.
// A line feed starts a pass over the stored line held in a single-port RAM
// with a registered read: one character per cycle, in up to two passes
// (prefix compare with +SRECV: search and comma count, then number
// fields).
// One request is worked at a time; req_ready is low during the pass and
// while a response waits in the output register.
// csr_ channel writes the scan enable bit; write only while idle.
// Reset (synchronous, active high) returns to line mode with an empty line,
// clears the chunk count, the desync counter and flags and drops a waiting
// response; the line RAM is not cleared since only written entries are ever read.
// When rsp_ready is low the response holds in its register and no further
// request is taken.
module at_response_stream_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  atrsp_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output atrsp_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);
   import atrsp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,  // read last char for CR strip
      ST_FIX   = 7'b0000100,
      ST_SCAN  = 7'b0001000,  // linear walk over the line
      ST_DECIDE= 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_PEND  = 7'b1000000
   } state_type;

   // walk phases
   typedef enum logic [3:0] {
      PH_PREFIX = 4'b0001,  // compare first 10 chars, search +SRECV:, count commas
      PH_SRECV  = 4'b0010,  // numbers after +SRECV:
      PH_NUM    = 4'b0100,  // +SCLOSED: id
      PH_PING   = 4'b1000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [7:0]  line_mem [LineBuf];
   logic [7:0]  rd_ff;
   logic [AddrW-1:0] raddr;
   logic        rd_en;

   logic             scan_en_ff;
   logic             data_mode_ff, data_mode_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [LenW-1:0]  clen_ff, clen_in;
   logic [10:0]      left_ff, left_in;
   logic [1:0]       csock_ff, csock_in;
   logic             seen_ff, seen_in;
   logic             dsa_ff, dsa_in;
   logic [15:0]      dcnt_ff, dcnt_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rspv_ff, rspv_in;

   // walk registers
   logic [LenW-1:0]  pos_ff, pos_in;      // index of char arriving in rd_ff
   logic             rdv_ff, rdv_in;
   logic [14:0]      pmatch_ff, pmatch_in; // prefix matches so far
   logic [6:0]       sr_ff, sr_in;         // +SRECV: window match pipeline
   logic             srf_ff, srf_in;
   logic [LenW-1:0]  srpos_ff, srpos_in;
   logic [1:0]       commas_ff, commas_in;
   logic [2:0]       sub_ff, sub_in;       // field step inside a number phase
   logic [11:0]      n1_ff, n1_in, n2_ff, n2_in;
   logic             neg_ff, neg_in;
   logic [31:0]      mag_ff, mag_in;
   logic             done_ff, done_in;

   logic req_fire, rsp_fire;
   logic [7:0] c;
   logic [11:0] n_next;
   logic [35:0] m_next;
   logic [3:0]  dig;

   localparam int NPfx = 14;
   logic [8*10-1:0] pat [NPfx];
   logic [3:0]      plen [NPfx];
   assign pat[0] = TxtOk;       assign plen[0] = 4'd2;
   assign pat[1] = TxtError;    assign plen[1] = 4'd6;
   assign pat[2] = TxtSendOk;   assign plen[2] = 4'd7;
   assign pat[3] = TxtSendFail; assign plen[3] = 4'd9;
   assign pat[4] = TxtPrompt;   assign plen[4] = 4'd1;
   assign pat[5] = TxtReady;    assign plen[5] = 4'd6;
   assign pat[6] = TxtSclosed;  assign plen[6] = 4'd9;
   assign pat[7] = TxtWjoin;    assign plen[7] = 4'd7;
   assign pat[8] = TxtWconn;    assign plen[8] = 4'd7;
   assign pat[9] = TxtWdisc;    assign plen[9] = 4'd9;
   assign pat[10]= TxtPing;     assign plen[10]= 4'd6;
   assign pat[11]= TxtPingstat; assign plen[11]= 4'd10;
   assign pat[12]= TxtResolve;  assign plen[12]= 4'd9;
   assign pat[13]= TxtWscan;    assign plen[13]= 4'd7;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign c   = rd_ff;
   assign dig = c[3:0];
   assign n_next = ({n1_ff} * 12'd10 + {8'd0, dig} > {1'b0, NumCap}) ? NumCap
                   : 12'(n1_ff * 12'd10 + {8'd0, dig});

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_en_ff <= 1'b0;
      end else if (csr_valid) begin
         scan_en_ff <= csr_data;
      end
   end

   // line RAM: write on byte store, registered read
   always_ff @(posedge clock) begin
      if (req_fire && req_data.cmd == CMD_BYTE && !data_mode_ff &&
          req_data.rx_byte != 8'h0a && len_ff < LenW'(LineBuf - 1)) begin
         line_mem[len_ff[AddrW-1:0]] <= req_data.rx_byte;
      end
      if (rd_en) begin
         rd_ff <= line_mem[raddr];
      end
   end

   always_comb begin
      state_in = state_ff;  phase_in = phase_ff;
      data_mode_in = data_mode_ff; len_in = len_ff; clen_in = clen_ff;
      left_in = left_ff; csock_in = csock_ff; seen_in = seen_ff;
      dsa_in = dsa_ff; dcnt_in = dcnt_ff; rsp_in = rsp_ff; rspv_in = rspv_ff;
      pos_in = pos_ff; rdv_in = 1'b0; pmatch_in = pmatch_ff; sr_in = sr_ff;
      srf_in = srf_ff; srpos_in = srpos_ff; commas_in = commas_ff;
      sub_in = sub_ff; n1_in = n1_ff; n2_in = n2_ff; neg_in = neg_ff;
      mag_in = mag_ff; done_in = done_ff;
      rd_en = 1'b0; raddr = '0;
      m_next = '0;
      if (rsp_fire) rspv_in = 1'b0;
      rsp_in = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_NEWCONN) begin
                  seen_in = 1'b0; dsa_in = 1'b0; dcnt_in = '0;
               end else if (data_mode_ff) begin
                  seen_in = 1'b1;
                  left_in = (left_ff != 11'd0) ? left_ff - 11'd1 : 11'd0;
                  rsp_in = '0;
                  rsp_in.event_res = EV_DATA;
                  rsp_in.socket_id = csock_ff;
                  rsp_in.payload_byte = req_data.rx_byte;
                  rsp_in.chunk_last = (left_ff <= 11'd1);
                  if (left_ff <= 11'd1) begin
                     data_mode_in = 1'b0; len_in = '0;
                  end
                  state_in = ST_PEND;
               end else if (req_data.rx_byte == 8'h0a) begin
                  clen_in = len_ff; len_in = '0;
                  if (len_ff != '0) begin
                     state_in = ST_PREP;
                  end
               end else if (len_ff < LenW'(LineBuf - 1)) begin
                  len_in = len_ff + LenW'(1);
               end
            end
         end
         ST_PREP: begin
            rd_en = 1'b1; raddr = AddrW'(clen_ff - LenW'(1));
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (c == 8'h0d) clen_in = clen_ff - LenW'(1);
            if (c == 8'h0d && clen_ff == LenW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN; phase_in = PH_PREFIX; pos_in = '0;
               pmatch_in = '1; sr_in = '0; srf_in = 1'b0; commas_in = '0;
               rd_en = 1'b1; raddr = '0; rdv_in = 1'b1; done_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue next read; rdv_ff says rd_ff holds char at pos_ff
            if (rdv_ff) begin
               case (phase_ff)
                  PH_PREFIX: begin
                     for (int k = 0; k < NPfx; k++) begin
                        if (pos_ff < LenW'(plen[k]) &&
                            c != pat[k][8*(9-pos_ff[3:0]) +: 8])
                           pmatch_in[k] = 1'b0;
                     end
                     // window: sr[j] = chars pos-j..pos match "+SRECV:"[0..j]
                     for (int j = 6; j > 0; j--)
                        sr_in[j] = sr_ff[j-1] && (c == TxtSrecv[8*(6-j) +: 8]);
                     sr_in[0] = (c == TxtSrecv[55:48]);
                     if (sr_in[6] && !srf_ff) begin
                        srf_in = 1'b1; srpos_in = pos_ff + LenW'(1);
                     end
                     if (pos_ff >= LenW'(7) && c == 8'h2c && commas_ff != 2'd3)
                        commas_in = commas_ff + 2'd1;
                  end
                  PH_SRECV, PH_NUM: begin
                     // sub 0: id digits up to the comma, 2: len digits
                     if (sub_ff == 3'd0 && is_digit(c)) n1_in = n_next;
                     else if (sub_ff == 3'd0) begin
                        if (phase_ff == PH_NUM) done_in = 1'b1;
                        else if (c == 8'h2c) sub_in = 3'd2;
                        else begin sub_in = 3'd2; n2_in = n1_ff; n1_in = '0;
                           done_in = !is_digit(c); end
                     end else begin
                        if (is_digit(c)) begin
                           // n2 keeps id, n1 the length
                           n1_in = n_next;
                        end else done_in = 1'b1;
                     end
                     if (sub_ff == 3'd0 && !is_digit(c) && phase_ff == PH_SRECV
                         && c == 8'h2c) begin
                        n2_in = n1_ff; n1_in = '0;
                     end
                  end
                  default: begin // PH_PING
                     // sub 0 digits and optional comma,2 blanks and sign,4 mag
                     case (sub_ff)
                        3'd0: if (!is_digit(c)) begin
                           if (c == 8'h2c) sub_in = 3'd2;
                           else if (is_blank(c)) sub_in = 3'd2;
                           else if (c == 8'h2d || c == 8'h2b) begin
                              neg_in = (c == 8'h2d); sub_in = 3'd4;
                           end else done_in = 1'b1;
                        end
                        3'd2: if (!is_blank(c)) begin
                           if (c == 8'h2d || c == 8'h2b) begin
                              neg_in = (c == 8'h2d); sub_in = 3'd4;
                           end else if (is_digit(c)) begin
                              mag_in = {28'd0, dig}; sub_in = 3'd4;
                           end else done_in = 1'b1;
                        end
                        default: if (is_digit(c)) begin
                           m_next = {4'd0, mag_ff} * 36'd10 + {32'd0, dig};
                           mag_in = (m_next > 36'h080000000) ? 32'h80000000
                                    : m_next[31:0];
                        end else done_in = 1'b1;
                     endcase
                  end
               endcase
            end
            if (rdv_ff && (pos_ff + LenW'(1) >= clen_ff || done_in)) begin
               state_in = ST_DECIDE;
            end else begin
               pos_in = rdv_ff ? pos_ff + LenW'(1) : pos_ff;
               rd_en = 1'b1; raddr = AddrW'(pos_in); rdv_in = 1'b1;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            rsp_in = '0;
            case (phase_ff)
               PH_PREFIX: begin
                  if (pmatch_ff[0] && clen_ff == LenW'(2)) begin
                     rsp_in.event_res = EV_OK; state_in = ST_PEND;
                  end else if (pmatch_ff[1] && clen_ff >= LenW'(6)) begin
                     rsp_in.event_res = EV_ERROR; state_in = ST_PEND;
                  end else if (pmatch_ff[2] && clen_ff == LenW'(7)) begin
                     rsp_in.event_res = EV_SEND_OK; state_in = ST_PEND;
                  end else if (pmatch_ff[3] && clen_ff == LenW'(9)) begin
                     rsp_in.event_res = EV_SEND_FAIL; state_in = ST_PEND;
                  end else if (pmatch_ff[4] && clen_ff == LenW'(1)) begin
                     rsp_in.event_res = EV_PROMPT; state_in = ST_PEND;
                  end else if (pmatch_ff[5] && clen_ff == LenW'(6)) begin
                     rsp_in.event_res = EV_READY; state_in = ST_PEND;
                  end else if (srf_ff) begin
                     state_in = ST_SCAN; phase_in = PH_SRECV; pos_in = srpos_ff;
                     sub_in = '0; n1_in = '0; n2_in = '0; done_in = 1'b0;
                     if (srpos_ff >= clen_ff) state_in = ST_DECIDE;
                     else begin rd_en = 1'b1; raddr = AddrW'(srpos_ff);
                        rdv_in = 1'b1; end
                  end else if (pmatch_ff[6] && clen_ff >= LenW'(9)) begin
                     state_in = ST_SCAN; phase_in = PH_NUM; pos_in = LenW'(9);
                     sub_in = '0; n1_in = '0; done_in = 1'b0;
                     if (clen_ff == LenW'(9)) state_in = ST_DECIDE;
                     else begin rd_en = 1'b1; raddr = AddrW'(9); rdv_in = 1'b1; end
                  end else if ((pmatch_ff[7] || pmatch_ff[8]) && clen_ff >= LenW'(7))
                  begin
                     rsp_in.event_res = EV_WIFI_UP; state_in = ST_PEND;
                  end else if (pmatch_ff[9] && clen_ff == LenW'(9)) begin
                     rsp_in.event_res = EV_WIFI_DOWN; state_in = ST_PEND;
                  end else if (pmatch_ff[10] && clen_ff >= LenW'(6)) begin
                     state_in = ST_SCAN; phase_in = PH_PING; pos_in = LenW'(6);
                     sub_in = '0; neg_in = 1'b0; mag_in = '0; done_in = 1'b0;
                     if (clen_ff == LenW'(6)) state_in = ST_DECIDE;
                     else begin rd_en = 1'b1; raddr = AddrW'(6); rdv_in = 1'b1; end
                  end else if (pmatch_ff[11] && clen_ff >= LenW'(10)) begin
                     state_in = ST_IDLE;
                  end else if (pmatch_ff[12] && clen_ff >= LenW'(9)) begin
                     rsp_in.event_res = EV_RESOLVE; state_in = ST_PEND;
                  end else if (pmatch_ff[13] && clen_ff >= LenW'(7) && scan_en_ff)
                  begin
                     if (commas_ff == 2'd3) begin
                        rsp_in.event_res = EV_SCAN; state_in = ST_PEND;
                     end
                  end else if (seen_ff && !dsa_ff) begin
                     dsa_in = 1'b1;
                     dcnt_in = (dcnt_ff != 16'hffff) ? dcnt_ff + 16'd1 : dcnt_ff;
                     rsp_in.event_res = EV_DESYNC;
                     rsp_in.event_value = {16'd0, dcnt_in};
                     state_in = ST_PEND;
                  end
               end
               PH_SRECV: begin
                  // id in n2 when a length field was reached, else in n1
                  if (sub_ff == 3'd2 && n2_ff < 12'(MaxSockets) && n1_ff != '0)
                  begin
                     csock_in = n2_ff[1:0];
                     left_in = (n1_ff > 12'(MaxChunk)) ? 11'(MaxChunk)
                               : n1_ff[10:0];
                     data_mode_in = 1'b1; dsa_in = 1'b0;
                  end
               end
               PH_NUM: begin
                  if (n1_ff < 12'(MaxSockets)) begin
                     rsp_in.event_res = EV_CLOSED;
                     rsp_in.socket_id = n1_ff[1:0];
                     state_in = ST_PEND;
                  end
               end
               default: begin
                  rsp_in.event_res = EV_PING;
                  rsp_in.event_value = neg_ff ? 32'(-mag_ff)
                     : ((mag_ff > 32'h7fffffff) ? 32'h7fffffff : mag_ff);
                  state_in = ST_PEND;
               end
            endcase
         end
         ST_PEND: begin
            rspv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; phase_ff <= PH_PREFIX;
         data_mode_ff <= 1'b0; len_ff <= '0; left_ff <= '0; csock_ff <= '0;
         seen_ff <= 1'b0; dsa_ff <= 1'b0; dcnt_ff <= '0; rspv_ff <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in;
         data_mode_ff <= data_mode_in; len_ff <= len_in; left_ff <= left_in;
         csock_ff <= csock_in; seen_ff <= seen_in; dsa_ff <= dsa_in;
         dcnt_ff <= dcnt_in; rspv_ff <= rspv_in; rdv_ff <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      clen_ff <= clen_in; rsp_ff <= rsp_in; pos_ff <= pos_in;
      pmatch_ff <= pmatch_in; sr_ff <= sr_in; srf_ff <= srf_in;
      srpos_ff <= srpos_in; commas_ff <= commas_in; sub_ff <= sub_in;
      n1_ff <= n1_in; n2_ff <= n2_in; neg_ff <= neg_in; mag_ff <= mag_in;
      done_ff <= done_in;
   end

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   a_data_sock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == EV_DATA |-> !rsp_data.chunk_last ||
      !data_mode_ff) else $error("last data byte left data mode set");
endmodule
